// ----- rtl/cwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared types and constants for the congestion window controller.
// ----------------------------------------------------------------------------
package cwc_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam logic [7:0]  DUP_MAX     = 8'd255;
  localparam logic [7:0]  DUP_TRIG    = 8'd3;
  localparam logic [15:0] SEQ_BACK    = 16'd3;
  localparam logic [15:0] WIN_RESTART = 16'd2;
  localparam logic [15:0] WIN_MAX     = 16'hFFFF;

  localparam logic [6:0]  RST_IWIN = 7'd10;
  localparam logic [15:0] RST_ITHR = 16'd1000;
  localparam logic [31:0] RST_IRTT = 32'd1200;
  localparam logic [31:0] RST_TMO  = 32'd1000;

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_ACK   = 2'd1,
    OP_TIMER = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_IWIN   = 3'd0,
    CFG_ITHR   = 3'd1,
    CFG_IRTT   = 3'd2,
    CFG_TMO    = 3'd3,
    CFG_TOTAL  = 3'd4,
    CFG_ENABLE = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEND,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_POST,
    S_RTT_DIFF,
    S_RTT_AVG,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FR,
    S_FR_CHK,
    S_WIN,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] packet_seq;
    logic        ecn_mark;
    logic [31:0] now_time;
  } cwc_in_t;

  typedef struct packed {
    logic        sent_valid;
    logic        retransmit_valid;
    logic [15:0] out_seq;
    logic        timer_armed;
    logic [31:0] timer_due;
    logic [15:0] window_now;
    logic [31:0] rtt_now;
    logic [31:0] send_gap;
    logic        all_sent;
  } cwc_out_t;

  typedef struct packed {
    logic             we_seq;
    logic             we_time;
    logic [IDX_W-1:0] waddr;
    logic [15:0]      wseq;
    logic [31:0]      wtime;
    logic [IDX_W-1:0] raddr;
  } cwc_mem_ctl_t;

endpackage

// ----- rtl/cwc_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_list
// Pending list storage: sequence and send time, one write, one registered read.
// ----------------------------------------------------------------------------
module cwc_list import cwc_pkg::*; (
  input  logic         clk,
  input  cwc_mem_ctl_t ctl,
  output logic [15:0]  rd_seq,
  output logic [31:0]  rd_time
);

  logic [15:0] mem_seq  [LIST_DEPTH];
  logic [31:0] mem_time [LIST_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we_seq) begin
      mem_seq[ctl.waddr] <= ctl.wseq;
    end
    if (ctl.we_time) begin
      mem_time[ctl.waddr] <= ctl.wtime;
    end
    rd_seq  <= mem_seq[ctl.raddr];
    rd_time <= mem_time[ctl.raddr];
  end

endmodule

// ----- rtl/cwc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_div
// Serial restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module cwc_div import cwc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [15:0] dsr;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem, quotient[31]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? 16'(trial - {1'b0, dsr}) : trial[15:0];
      quotient <= {quotient[30:0], fits};
    end
  end

endmodule

// ----- rtl/congestion_window_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// congestion_window_controller
// Sender-side congestion window control with slow start and AIMD.
// ----------------------------------------------------------------------------
// One event at a time. The pending list lives in a single-port-read memory
// that a sequencer walks entry by entry, through a read state and a check
// state for a scan and a read state and a write state for the shift that
// closes the gap behind a removed entry. Every event ends with a run of the
// serial divider for the pacing gap. Config writes are taken only while idle.
module congestion_window_controller import cwc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  cwc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output cwc_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state, state_next;
  cwc_mem_ctl_t mem;
  logic [15:0] rd_seq;
  logic [31:0] rd_time;
  logic div_start, div_done;
  logic [31:0] quotient;

  // config
  logic [31:0] tmo;
  logic [15:0] total;
  logic        en;

  // block state
  logic [CNT_W-1:0] count, ri, idx;
  logic [7:0]  dup;
  logic [15:0] window, threshold, next_seq;
  logic [31:0] rtt, round_first, round_last;
  logic        decrease_flag, slow_start_flag;

  // current event
  op_t         op;
  logic [15:0] seq;
  logic        ecn;
  logic [31:0] now;
  logic        sent, retx, armed, head_match, found;
  logic [15:0] oseq;
  logic [IDX_W-1:0] fidx;
  logic [31:0] ftime, bdiff;

  logic send_ok, fr_ok, fr_hit, out_free;
  logic [15:0] win_calc, win_half;
  logic        dflag;
  logic [6:0]  iwin;

  cwc_list u_list (.clk(clk), .ctl(mem), .rd_seq(rd_seq), .rd_time(rd_time));

  cwc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(rtt), .divisor(window),
    .done(div_done), .quotient(quotient)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign iwin      = cfg_data[6:0];

  assign send_ok = (next_seq < total) && ({9'd0, count} < window)
                   && (count < CNT_W'(LIST_DEPTH));
  assign fr_ok   = (dup >= DUP_TRIG) && (ri < count) && (seq >= SEQ_BACK);
  assign fr_hit  = rd_seq <= 16'(seq - SEQ_BACK);

  assign dflag    = decrease_flag | ecn;
  assign win_half = {1'b0, window[15:1]};
  always_comb begin
    if (dflag) begin
      win_calc = (win_half == 16'd0) ? 16'd1 : win_half;
    end else if (window < threshold) begin
      win_calc = window[15] ? WIN_MAX : {window[14:0], 1'b0};
    end else if (window != WIN_MAX) begin
      win_calc = window + 16'd1;
    end else begin
      win_calc = window;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem        = '0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_data.operation))
            OP_SEND:           state_next = S_SEND;
            OP_ACK, OP_TIMER:  state_next = (count == '0) ? S_POST : S_SCAN_RD;
            default:           state_next = S_DIV_START;
          endcase
        end
      end
      S_SEND: begin
        mem.we_seq  = send_ok;
        mem.we_time = send_ok;
        mem.waddr   = count[IDX_W-1:0];
        mem.wseq    = next_seq;
        mem.wtime   = now;
        state_next  = S_DIV_START;
      end
      S_SCAN_RD: begin
        mem.raddr  = idx[IDX_W-1:0];
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rd_seq == seq || CNT_W'(idx + 1'b1) >= count) begin
          state_next = S_POST;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_POST: begin
        if (op == OP_TIMER) begin
          mem.we_time = found && (fidx == '0);
          mem.waddr   = '0;
          mem.wtime   = now;
          state_next  = S_DIV_START;
        end else begin
          state_next = found ? S_RTT_DIFF : S_FR;
        end
      end
      S_RTT_DIFF: state_next = S_RTT_AVG;
      S_RTT_AVG:  state_next = S_SHIFT_RD;
      S_SHIFT_RD: begin
        if (CNT_W'(idx + 1'b1) < count) begin
          mem.raddr  = IDX_W'(idx + 1'b1);
          state_next = S_SHIFT_WR;
        end else begin
          state_next = S_FR;
        end
      end
      S_SHIFT_WR: begin
        mem.we_seq  = 1'b1;
        mem.we_time = 1'b1;
        mem.waddr   = idx[IDX_W-1:0];
        mem.wseq    = rd_seq;
        mem.wtime   = rd_time;
        state_next  = S_SHIFT_RD;
      end
      S_FR: begin
        mem.raddr  = ri[IDX_W-1:0];
        state_next = fr_ok ? S_FR_CHK : S_WIN;
      end
      S_FR_CHK: begin
        mem.we_time = fr_hit;
        mem.waddr   = ri[IDX_W-1:0];
        mem.wtime   = now;
        state_next  = S_WIN;
      end
      S_WIN:       state_next = S_DIV_START;
      S_DIV_START: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT:  state_next = div_done ? S_DONE : S_DIV_WAIT;
      S_DONE:      state_next = out_free ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tmo             <= RST_TMO;
      total           <= '0;
      en              <= 1'b1;
      count           <= '0;
      ri              <= '0;
      dup             <= '0;
      window          <= {9'd0, RST_IWIN};
      threshold       <= RST_ITHR;
      rtt             <= RST_IRTT;
      round_first     <= '0;
      round_last      <= {25'd0, RST_IWIN} - 32'd1;
      decrease_flag   <= 1'b0;
      slow_start_flag <= 1'b0;
      next_seq        <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
              CFG_IWIN: begin
                window      <= (iwin == 7'd0) ? 16'd1 : {9'd0, iwin};
                round_first <= '0;
                round_last  <= (iwin == 7'd0) ? 32'd0 : {25'd0, iwin} - 32'd1;
              end
              CFG_ITHR:   threshold <= cfg_data[15:0];
              CFG_IRTT:   rtt       <= cfg_data;
              CFG_TMO:    tmo       <= cfg_data;
              CFG_TOTAL:  total     <= cfg_data[15:0];
              CFG_ENABLE: en        <= cfg_data[0];
              default: ;
            endcase
          end
        end
        S_SEND: begin
          if (send_ok) begin
            count    <= CNT_W'(count + 1'b1);
            next_seq <= next_seq + 16'd1;
          end
        end
        S_POST: begin
          if (op == OP_ACK) begin
            if (head_match) begin
              dup <= '0;
            end else if (dup != DUP_MAX) begin
              dup <= dup + 8'd1;
            end
          end else if (found && fidx == '0) begin
            window          <= WIN_RESTART;
            slow_start_flag <= 1'b1;
          end
        end
        S_RTT_AVG: begin
          rtt <= {1'b0, rtt[31:1]} + {1'b0, bdiff[31:1]} + {31'd0, rtt[0] & bdiff[0]};
          if ({1'b0, fidx} < ri) begin
            ri <= CNT_W'(ri - 1'b1);
          end
        end
        S_SHIFT_RD: begin
          if (CNT_W'(idx + 1'b1) >= count) begin
            count <= CNT_W'(count - 1'b1);
          end
        end
        S_FR_CHK: begin
          if (fr_hit) begin
            if ({16'd0, rd_seq} >= round_first) begin
              decrease_flag <= 1'b1;
            end
            ri <= CNT_W'(ri + 1'b1);
          end
        end
        S_WIN: begin
          if ({16'd0, seq} >= round_last) begin
            window <= win_calc;
            if (dflag) begin
              if (slow_start_flag) begin
                slow_start_flag <= 1'b0;
              end else begin
                threshold <= win_half;
              end
            end
            decrease_flag <= 1'b0;
            round_first   <= round_last;
            round_last    <= round_last + {16'd0, win_calc};
          end else begin
            decrease_flag <= dflag;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // per-event working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op         <= op_t'(in_data.operation);
        seq        <= in_data.packet_seq;
        ecn        <= in_data.ecn_mark;
        now        <= in_data.now_time;
        sent       <= 1'b0;
        retx       <= 1'b0;
        armed      <= 1'b0;
        oseq       <= '0;
        head_match <= 1'b0;
        found      <= 1'b0;
        idx        <= '0;
      end
      S_SEND: begin
        if (send_ok) begin
          sent  <= 1'b1;
          armed <= 1'b1;
          oseq  <= next_seq;
        end
      end
      S_SCAN_CHK: begin
        if (rd_seq == seq) begin
          found <= 1'b1;
          fidx  <= idx[IDX_W-1:0];
          ftime <= rd_time;
          if (idx == '0) begin
            head_match <= 1'b1;
          end
        end else begin
          idx <= CNT_W'(idx + 1'b1);
        end
      end
      S_POST: begin
        if (op == OP_TIMER && found) begin
          retx  <= (fidx == '0);
          armed <= 1'b1;
          oseq  <= seq;
        end
      end
      S_RTT_DIFF: bdiff <= now - ftime;
      S_RTT_AVG:  idx   <= {1'b0, fidx};
      S_SHIFT_WR: idx   <= CNT_W'(idx + 1'b1);
      S_FR_CHK: begin
        if (fr_hit) begin
          retx  <= 1'b1;
          armed <= 1'b1;
          oseq  <= rd_seq;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data.sent_valid       <= sent;
          out_data.retransmit_valid <= retx;
          out_data.out_seq          <= oseq;
          out_data.timer_armed      <= armed & en;
          out_data.timer_due        <= (armed & en) ? now + tmo : 32'd0;
          out_data.window_now       <= window;
          out_data.rtt_now          <= rtt;
          out_data.send_gap         <= quotient;
          out_data.all_sent         <= next_seq >= total;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- verif/congestion_window_controller_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// congestion_window_controller_tb
// Self-checking bench: drives send/ack/timer events through the congestion
// controller under bursty input and a stalling receiver, predicts every
// result beat from a behavioral model of the window and pending list, and
// compares each field. Runs several register settings, extremes included.
// ----------------------------------------------------------------------------
module congestion_window_controller_tb;
  import cwc_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  cwc_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  cwc_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  congestion_window_controller u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  cwc_in_t  event_q[$];
  cwc_out_t expected_q[$];
  int       err_cnt;
  int       result_cnt;

  // controller shadow: registers
  logic [6:0]  m_iwin;
  logic [15:0] m_ithr;
  logic [31:0] m_irtt;
  logic [31:0] m_tmo;
  logic [15:0] m_total;
  logic        m_en;
  // controller shadow: state
  logic [15:0] m_pseq [LIST_DEPTH];
  logic [31:0] m_ptime[LIST_DEPTH];
  int unsigned m_pcount;
  int unsigned m_dup;
  int unsigned m_ridx;
  int unsigned m_win;
  int unsigned m_thr;
  logic [31:0] m_rtt;
  logic [31:0] m_rfirst;
  logic [31:0] m_rlast;
  logic        m_dec;
  logic        m_slow;
  int unsigned m_nseq;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic int find_pending(logic [15:0] s);
    for (int k = 0; k < m_pcount; k++)
      if (m_pseq[k] == s) return k;
    return -1;
  endfunction

  function automatic void load_window();
    m_win    = (m_iwin == 0) ? 1 : m_iwin;
    m_rfirst = 32'd0;
    m_rlast  = m_win - 1;
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [31:0] val);
    case (idx)
      CFG_IWIN:   begin m_iwin = val[6:0]; load_window(); end
      CFG_ITHR:   begin m_ithr = val[15:0]; m_thr = m_ithr; end
      CFG_IRTT:   begin m_irtt = val; m_rtt = val; end
      CFG_TMO:    m_tmo = val;
      CFG_TOTAL:  m_total = val[15:0];
      CFG_ENABLE: m_en = val[0];
      default: ;
    endcase
  endfunction

  // Advance the shadow controller by one event and queue its result beat.
  function automatic void predict_event(cwc_in_t ev);
    cwc_out_t    r;
    logic [15:0] s;
    logic [31:0] a, b;
    logic [15:0] rs;
    int          i;
    r = '0;
    s = ev.packet_seq;
    case (op_t'(ev.operation))
      OP_SEND: begin
        if (m_nseq < m_total && m_pcount < m_win && m_pcount < LIST_DEPTH) begin
          m_pseq[m_pcount]  = m_nseq[15:0];
          m_ptime[m_pcount] = ev.now_time;
          m_pcount++;
          r.sent_valid = 1'b1;
          r.out_seq = m_nseq[15:0];
          r.timer_armed = 1'b1;
          m_nseq++;
        end
      end
      OP_ACK: begin
        if (m_pcount > 0 && m_pseq[0] == s) m_dup = 0;
        else if (m_dup < 255) m_dup++;
        i = find_pending(s);
        if (i >= 0) begin
          a = m_rtt;
          b = ev.now_time - m_ptime[i];
          if (i < m_ridx) m_ridx--;
          m_rtt = (a >> 1) + (b >> 1) + {31'd0, a[0] & b[0]};
          for (int k = i; k < m_pcount - 1; k++) begin
            m_pseq[k]  = m_pseq[k+1];
            m_ptime[k] = m_ptime[k+1];
          end
          m_pcount--;
        end
        if (m_dup >= 3 && m_ridx < m_pcount && s >= 3) begin
          rs = m_pseq[m_ridx];
          if (rs <= s - 16'd3) begin
            if ({16'd0, rs} >= m_rfirst) m_dec = 1'b1;
            r.retransmit_valid = 1'b1;
            r.out_seq = rs;
            r.timer_armed = 1'b1;
            m_ptime[m_ridx] = ev.now_time;
            m_ridx++;
          end
        end
        if (ev.ecn_mark) m_dec = 1'b1;
        if ({16'd0, s} >= m_rlast) begin
          if (m_dec) begin
            m_win = m_win >> 1;
            if (m_slow) m_slow = 1'b0;
            else m_thr = m_win;
            m_dec = 1'b0;
            if (m_win == 0) m_win = 1;
          end else if (m_win < m_thr) begin
            m_win = (m_win * 2 > 65535) ? 65535 : m_win * 2;
          end else if (m_win < 65535) begin
            m_win++;
          end
          m_rfirst = m_rlast;
          m_rlast  = m_rlast + m_win;
        end
      end
      OP_TIMER: begin
        i = find_pending(s);
        if (i == 0) begin
          m_win = 2;
          m_slow = 1'b1;
          r.retransmit_valid = 1'b1;
          r.out_seq = s;
          r.timer_armed = 1'b1;
          m_ptime[0] = ev.now_time;
        end else if (i > 0) begin
          r.out_seq = s;
          r.timer_armed = 1'b1;
        end
      end
      default: ;
    endcase
    if (!m_en) r.timer_armed = 1'b0;
    if (m_win == 0) m_win = 1;
    r.timer_due  = r.timer_armed ? ev.now_time + m_tmo : 32'd0;
    r.window_now = m_win[15:0];
    r.rtt_now    = m_rtt;
    r.send_gap   = m_rtt / m_win;
    r.all_sent   = (m_nseq >= m_total);
    expected_q = {expected_q, r};
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // driver: bursts of random length with random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left = 4;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) predict_event(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (event_q.size() > 0) begin
          in_data  <= event_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: own stall pattern plus two long hold-offs
  int unsigned stall_mode;
  int unsigned hold_left;
  int unsigned cyc;

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode = 0;
      hold_left  = 0;
      cyc        = 0;
    end else begin
      cyc++;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got %h", $realtime, out_data);
          err_cnt++;
        end else begin
          cwc_out_t e;
          e = expected_q.pop_front();
          check_field("sent_valid", e.sent_valid, out_data.sent_valid);
          check_field("retransmit_valid", e.retransmit_valid, out_data.retransmit_valid);
          check_field("out_seq", e.out_seq, out_data.out_seq);
          check_field("timer_armed", e.timer_armed, out_data.timer_armed);
          check_field("timer_due", e.timer_due, out_data.timer_due);
          check_field("window_now", e.window_now, out_data.window_now);
          check_field("rtt_now", e.rtt_now, out_data.rtt_now);
          check_field("send_gap", e.send_gap, out_data.send_gap);
          check_field("all_sent", e.all_sent, out_data.all_sent);
        end
        result_cnt++;
        if (result_cnt == 250 || result_cnt == 760) hold_left = 1500;
      end
      if (cyc % 3000 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // stimulus
  logic [31:0] g_now;
  int unsigned g_issued;
  logic [15:0] g_last_ack;

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [6:0] iw, logic [15:0] th, logic [31:0] rt,
                          logic [31:0] to, logic [15:0] tot, logic en);
    write_reg(CFG_IWIN, {25'd0, iw});
    write_reg(CFG_ITHR, {16'd0, th});
    write_reg(CFG_IRTT, rt);
    write_reg(CFG_TMO, to);
    write_reg(CFG_TOTAL, {16'd0, tot});
    write_reg(CFG_ENABLE, {31'd0, en});
  endtask

  // wait until the block has drained every beat, then settle
  task automatic drain();
    while (event_q.size() > 0 || expected_q.size() > 0 || in_valid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_event(op_t op, logic [15:0] s, logic ecn);
    cwc_in_t ev;
    if ($urandom_range(0, 31) == 0) g_now = $urandom;
    else g_now = g_now + $urandom_range(0, 3000);
    ev.operation  = op;
    ev.packet_seq = s;
    ev.ecn_mark   = ecn;
    ev.now_time   = g_now;
    event_q = {event_q, ev};
  endtask

  task automatic random_events(int n, int send_pct);
    int unsigned p;
    int          back;
    logic [15:0] s;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      back = $urandom_range(0, 70);
      s = (g_issued > back) ? 16'(g_issued - back) : 16'd0;
      if (p < send_pct) begin
        push_event(OP_SEND, 16'($urandom), 1'($urandom_range(0, 1)));
        g_issued++;
      end else if (p < send_pct + 35) begin
        if ($urandom_range(0, 3) == 0) s = g_last_ack;  // duplicate ack
        g_last_ack = s;
        push_event(OP_ACK, s, $urandom_range(0, 15) == 0);
      end else if (p < 95) begin
        push_event(OP_TIMER, s, 1'($urandom_range(0, 1)));
      end else begin
        push_event(op_t'($urandom_range(0, 3)), 16'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    err_cnt    = 0;
    result_cnt = 0;
    g_now      = 32'd100;
    g_issued   = 0;
    g_last_ack = 16'd0;
    m_iwin = RST_IWIN; m_ithr = RST_ITHR; m_irtt = RST_IRTT; m_tmo = RST_TMO;
    m_total = 16'd0; m_en = 1'b1;
    m_pcount = 0; m_dup = 0; m_ridx = 0; m_thr = RST_ITHR; m_rtt = RST_IRTT;
    m_dec = 1'b0; m_slow = 1'b0; m_nseq = 0;
    load_window();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-list and unknown cases at reset values, then a short flow
    push_event(OP_SEND, 16'd0, 1'b0);          // refused, total is zero
    push_event(OP_NONE, 16'hFFFF, 1'b1);
    push_event(OP_ACK, 16'd0, 1'b0);           // ack on empty list
    push_event(OP_TIMER, 16'd7, 1'b0);         // unknown seq
    drain();
    write_reg(CFG_TOTAL, 32'd6);
    repeat (7) push_event(OP_SEND, 16'd0, 1'b0);  // last one refused: all sent
    push_event(OP_TIMER, 16'd2, 1'b0);         // non-head entry: rearm
    push_event(OP_TIMER, 16'd0, 1'b0);         // head: retransmit, window 2
    push_event(OP_ACK, 16'd0, 1'b1);           // head ack with ECN
    repeat (4) push_event(OP_ACK, 16'd5, 1'b0);   // duplicates, fast retransmit
    push_event(OP_ACK, 16'hFFFF, 1'b0);        // not in list, boundary
    push_event(OP_ACK, 16'd9, 1'b0);
    g_issued = 6;
    drain();

    set_regs(7'd0, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    g_issued = m_nseq;
    random_events(150, 45);
    drain();
    set_regs(7'd64, 16'hFFFF, 32'd1, 32'd1, 16'hFFFF, 1'b1);
    g_issued = m_nseq;
    random_events(120, 80);                    // push sends against the 64-entry list limit
    random_events(150, 40);
    drain();
    set_regs(7'd127, 16'd4, 32'd5000, 32'd1000, 16'(m_nseq + 5), 1'b1);
    g_issued = m_nseq;
    random_events(100, 50);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      set_regs(7'($urandom_range(1, 64)), 16'($urandom), $urandom, $urandom, 16'hFFFF,
               1'($urandom_range(0, 1)));
      g_issued = m_nseq;
      random_events(170, 45);
      drain();
    end

    if (err_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cwc_pkg.sv
rtl/cwc_list.sv
rtl/cwc_div.sv
rtl/congestion_window_controller.sv
verif/congestion_window_controller_tb.sv
